FILE: hw/rtl/gbi_pkg.sv
`default_nettype none
package gbi_pkg;

  localparam int MaxRows       = 64;
  localparam int MaxCols       = 64;
  localparam int ValuesPerNode = 3;
  localparam int RowW          = $clog2(MaxRows);
  localparam int ColW          = $clog2(MaxCols);
  localparam int SlotW         = (ValuesPerNode > 1) ? $clog2(ValuesPerNode) : 1;
  localparam int StoreDepth    = MaxRows * MaxCols * ValuesPerNode;
  localparam int AddrW         = $clog2(StoreDepth);

  // register indexes
  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_COL_AXIS_X = 3'd2;
  localparam logic [2:0] REG_COL_AXIS_Y = 3'd3;
  localparam logic [2:0] REG_ROW_AXIS_X = 3'd4;
  localparam logic [2:0] REG_ROW_AXIS_Y = 3'd5;
  localparam logic [2:0] REG_NUM_ROWS   = 3'd6;
  localparam logic [2:0] REG_NUM_COLS   = 3'd7;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         node_row;
    logic [5:0]         node_col;
    logic [1:0]         value_slot;
    logic signed [31:0] load_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         result_slot;
    logic               inside_res;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STORE, ST_DIFF, ST_MUL, ST_SUM, ST_CELL, ST_WMUL,
    ST_RD, ST_RDW, ST_ACC, ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;     // capture input item
    logic       wr;       // node store write
    logic       diff;     // compute offsets
    logic [1:0] mul_sel;  // which projection product
    logic       mul;      // projection multiply step
    logic       sum;      // form grid coords
    logic       pick;     // pick cell, fractions
    logic       wmul;     // corner weight
    logic [1:0] corner;
    logic [SlotW-1:0] slot;
    logic       rd;       // issue memory read
    logic       vmul;     // value * weight
    logic       acc;      // accumulate
    logic       clr;      // clear accumulator
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd;
    logic in_grid;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gbi_ram.sv
`default_nettype none
module gbi_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/gbi_ctrl.sv
`default_nettype none
module gbi_ctrl
  import gbi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      out_last,
  output logic [SlotW-1:0] out_slot,
  input  wire sts_t sts,
  output ctl_t      ctl
);
  state_t state, state_next;
  logic [1:0] mstep, mstep_next;
  logic [1:0] corner, corner_next;
  logic [SlotW-1:0] slot, slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mstep  <= '0;
      corner <= '0;
      slot   <= '0;
    end else begin
      state  <= state_next;
      mstep  <= mstep_next;
      corner <= corner_next;
      slot   <= slot_next;
    end
  end

  assign out_slot = slot;
  assign out_last = (slot == SlotW'(ValuesPerNode - 1));

  // sequencing: per value, four corners each weight, read, multiply, accumulate
  always_comb begin
    state_next  = state;
    mstep_next  = mstep;
    corner_next = corner;
    slot_next   = slot;
    ctl         = '0;
    ctl.mul_sel = mstep;
    ctl.corner  = corner;
    ctl.slot    = slot;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        if (sts.cmd == CMD_STORE) begin
          ctl.wr     = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        ctl.diff   = 1'b1;
        mstep_next = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        mstep_next = mstep + 2'd1;
        if (mstep == 2'd3) state_next = ST_SUM;
      end
      ST_SUM: begin
        ctl.sum    = 1'b1;
        state_next = ST_CELL;
      end
      ST_CELL: begin
        ctl.pick    = 1'b1;
        slot_next   = '0;
        corner_next = '0;
        ctl.clr     = 1'b1;
        state_next  = sts.in_grid ? ST_WMUL : ST_EMIT;
      end
      ST_WMUL: begin
        ctl.wmul   = 1'b1;
        state_next = ST_RD;
      end
      ST_RD: begin
        ctl.rd     = 1'b1;
        state_next = ST_RDW;
      end
      ST_RDW: begin
        ctl.vmul   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc     = 1'b1;
        corner_next = corner + 2'd1;
        if (corner == 2'd3) state_next = ST_EMIT;
        else                state_next = ST_WMUL;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ctl.clr     = 1'b1;
          corner_next = '0;
          if (out_last) begin
            state_next = ST_IDLE;
          end else begin
            slot_next  = slot + SlotW'(1);
            state_next = sts.in_grid ? ST_WMUL : ST_EMIT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/gbi_datapath.sv
`default_nettype none
module gbi_datapath
  import gbi_pkg::*;
(
  input  wire logic               clk,
  input  wire in_item_t           in_item,
  input  wire ctl_t               ctl,
  output sts_t                    sts,
  input  wire logic signed [31:0] origin_x,
  input  wire logic signed [31:0] origin_y,
  input  wire logic signed [31:0] col_axis_x,
  input  wire logic signed [31:0] col_axis_y,
  input  wire logic signed [31:0] row_axis_x,
  input  wire logic signed [31:0] row_axis_y,
  input  wire logic [6:0]         num_rows,
  input  wire logic [6:0]         num_cols,
  output logic signed [31:0]      acc
);
  in_item_t item;
  logic signed [32:0] dx, dy;
  logic signed [64:0] prod;
  logic signed [44:0] pc0, pc1, pr0, pr1;
  logic signed [45:0] gc, gr;
  logic [RowW-1:0] r0;
  logic [ColW-1:0] c0;
  logic [16:0] fc, fr;
  logic [16:0] wgt;
  logic signed [49:0] vprod;
  logic [31:0] rdata;
  logic [AddrW-1:0] raddr, waddr;
  logic in_grid;

  // clamped grid size
  logic [10:0] rows_c, cols_c;
  always_comb begin
    rows_c = (num_rows < 7'd2) ? 11'd2 :
             (num_rows > 7'(MaxRows)) ? 11'(MaxRows) : 11'(num_rows);
    cols_c = (num_cols < 7'd2) ? 11'd2 :
             (num_cols > 7'(MaxCols)) ? 11'(MaxCols) : 11'(num_cols);
  end

  // node store
  assign waddr = AddrW'((32'(item.node_row) * MaxCols + 32'(item.node_col))
                 * ValuesPerNode + 32'(item.value_slot));
  logic wr_ok;
  assign wr_ok = (32'(item.node_row) < MaxRows) && (32'(item.node_col) < MaxCols)
                 && (32'(item.value_slot) < ValuesPerNode);

  logic [RowW:0] rsel;
  logic [ColW:0] csel;
  assign rsel = {1'b0, r0} + (RowW+1)'(ctl.corner[0]);
  assign csel = {1'b0, c0} + (ColW+1)'(ctl.corner[1]);
  assign raddr = AddrW'((32'(rsel) * MaxCols + 32'(csel)) * ValuesPerNode
                 + 32'(ctl.slot));

  gbi_ram #(.Width(32), .Depth(StoreDepth)) u_ram (
    .clk   (clk),
    .we    (ctl.wr && wr_ok),
    .waddr (waddr),
    .wdata (item.load_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // projection multiplier operands
  logic signed [32:0] ma;
  logic signed [31:0] mb;
  always_comb begin
    case (ctl.mul_sel)
      2'd0:    begin ma = dx; mb = col_axis_x; end
      2'd1:    begin ma = dy; mb = col_axis_y; end
      2'd2:    begin ma = dx; mb = row_axis_x; end
      default: begin ma = dy; mb = row_axis_y; end
    endcase
  end
  assign prod = 65'(ma) * 65'(mb);

  // grid coords and cell selection
  logic signed [45:0] gc_hi, gr_hi;
  logic signed [45:0] cmax, rmax;
  assign cmax = 46'(cols_c - 11'd1) <<< 16;
  assign rmax = 46'(rows_c - 11'd1) <<< 16;
  assign gc_hi = gc >>> 16;
  assign gr_hi = gr >>> 16;
  logic in_now;
  assign in_now = (gc >= 0) && (gr >= 0) && (gc <= cmax) && (gr <= rmax);

  logic [10:0] c0n, r0n;
  always_comb begin
    c0n = gc_hi[10:0];
    if (c0n == cols_c - 11'd1) c0n = c0n - 11'd1;
    r0n = gr_hi[10:0];
    if (r0n == rows_c - 11'd1) r0n = r0n - 11'd1;
  end

  // corner weight
  logic [16:0] cw, rw;
  logic [33:0] wp;
  assign cw = ctl.corner[1] ? fc : 17'd65536 - fc;
  assign rw = ctl.corner[0] ? fr : 17'd65536 - fr;
  assign wp = 34'(cw) * 34'(rw);

  // saturating accumulate
  logic signed [33:0] ssum;
  assign ssum = 34'(acc) + 34'(vprod >>> 16);

  always_ff @(posedge clk) begin
    if (ctl.load) item <= in_item;
    if (ctl.diff) begin
      dx <= 33'(item.point_x) - 33'(origin_x);
      dy <= 33'(item.point_y) - 33'(origin_y);
    end
    if (ctl.mul) begin
      case (ctl.mul_sel)
        2'd0:    pc0 <= 45'(prod >>> 20);
        2'd1:    pc1 <= 45'(prod >>> 20);
        2'd2:    pr0 <= 45'(prod >>> 20);
        default: pr1 <= 45'(prod >>> 20);
      endcase
    end
    if (ctl.sum) begin
      gc <= 46'(pc0) + 46'(pc1);
      gr <= 46'(pr0) + 46'(pr1);
    end
    if (ctl.pick) begin
      in_grid <= in_now;
      c0 <= ColW'(c0n);
      r0 <= RowW'(r0n);
      fc <= 17'(gc - (46'(c0n) <<< 16));
      fr <= 17'(gr - (46'(r0n) <<< 16));
    end
    if (ctl.wmul) wgt <= 17'(wp >> 16);
    if (ctl.vmul) vprod <= 50'($signed(rdata)) * 50'($signed({1'b0, wgt}));
    if (ctl.clr) acc <= '0;
    else if (ctl.acc) begin
      if (ssum > 34'sd2147483647)       acc <= 32'sh7FFFFFFF;
      else if (ssum < -34'sd2147483648) acc <= 32'sh80000000;
      else                              acc <= 32'(ssum);
    end
  end

  // the cell step decides on the fresh bounds test, later steps on the stored one
  assign sts.cmd     = item.cmd;
  assign sts.in_grid = ctl.pick ? in_now : in_grid;
endmodule
`default_nettype wire

FILE: hw/rtl/grid_bilinear_interpolator_core.sv
// Bilinear interpolator over a regular grid of up to 64 x 64 nodes, three
// Q16.16 values per node. Store items write one value. Query items project
// (point - origin) onto the column/row axes through one shared 33x32
// multiplier, then per value walk the four corners through the node RAM.
// Results come out in slot order with last on the final one; outside points
// give zeros with inside_res low. Node store contents are undefined until
// written. Config writes are taken any time and must only happen when idle.
`default_nettype none
module grid_bilinear_interpolator_core
  import gbi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic signed [31:0] origin_x, origin_y, col_axis_x, col_axis_y;
  logic signed [31:0] row_axis_x, row_axis_y;
  logic [6:0] num_rows, num_cols;
  ctl_t ctl;
  sts_t sts;
  logic last;
  logic [SlotW-1:0] slot;
  logic signed [31:0] acc;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      col_axis_x <= 32'sd65536;
      col_axis_y <= '0;
      row_axis_x <= '0;
      row_axis_y <= 32'sd65536;
      num_rows   <= 7'd2;
      num_cols   <= 7'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x   <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data;
        REG_COL_AXIS_X: col_axis_x <= cfg_data;
        REG_COL_AXIS_Y: col_axis_y <= cfg_data;
        REG_ROW_AXIS_X: row_axis_x <= cfg_data;
        REG_ROW_AXIS_Y: row_axis_y <= cfg_data;
        REG_NUM_ROWS:   num_rows   <= cfg_data[6:0];
        REG_NUM_COLS:   num_cols   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  gbi_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .out_last (last), .out_slot (slot), .sts, .ctl
  );

  gbi_datapath u_dp (
    .clk, .in_item (in_data), .ctl, .sts,
    .origin_x, .origin_y, .col_axis_x, .col_axis_y,
    .row_axis_x, .row_axis_y, .num_rows, .num_cols, .acc
  );

  assign out_data.result_value = sts.in_grid ? acc : 32'sd0;
  assign out_data.result_slot  = 2'(slot);
  assign out_data.inside_res   = sts.in_grid;
  assign out_data.last         = last;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready)
    else $error("not idle after last result");
  a_store_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cmd == CMD_STORE |=> ##1 !out_valid)
    else $error("store produced a result");
endmodule
`default_nettype wire
